// ===== hw/rtl/rlt_pkg.sv =====
package rlt_pkg;

	localparam int NUM_LOCKS_DEF   = 12;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int IDX_W    = 4;
	localparam int TAG_W    = 32;
	localparam int TYPE_W   = 8;
	localparam int STATUS_W = 4;
	localparam int DEPTH_W  = 16;
	localparam int MASK_W   = 12;
	localparam int CFG_W    = 4;
	localparam int PTR_W    = 5;

	localparam logic [1:0]        OWNER_FREE = 2'd2;
	localparam logic [TYPE_W-1:0] TYPE_RESET = 8'd2;

	localparam logic [CFG_W-1:0] POOL_FIRST_RST = 4'd5;
	localparam logic [CFG_W-1:0] POOL_LAST_RST  = 4'd11;

	localparam logic REG_POOL_FIRST = 1'b0;
	localparam logic REG_POOL_LAST  = 1'b1;

	localparam logic [2:0] REQ_TRYLOCK  = 3'd0;
	localparam logic [2:0] REQ_LOCK     = 3'd1;
	localparam logic [2:0] REQ_UNLOCK   = 3'd2;
	localparam logic [2:0] REQ_ALLOCATE = 3'd3;
	localparam logic [2:0] REQ_RETURN   = 3'd4;
	localparam logic [2:0] REQ_CLEANUP  = 3'd5;
	localparam logic [2:0] REQ_SET_TYPE = 3'd6;
	localparam logic [2:0] REQ_UNUSED   = 3'd7;

	localparam logic [STATUS_W-1:0] ST_NEW          = 4'd0;
	localparam logic [STATUS_W-1:0] ST_NESTED       = 4'd1;
	localparam logic [STATUS_W-1:0] ST_TRY_FAILED   = 4'd2;
	localparam logic [STATUS_W-1:0] ST_RETRY        = 4'd3;
	localparam logic [STATUS_W-1:0] ST_UNLOCKED_ONE = 4'd4;
	localparam logic [STATUS_W-1:0] ST_FREED        = 4'd5;
	localparam logic [STATUS_W-1:0] ST_IGNORED      = 4'd6;
	localparam logic [STATUS_W-1:0] ST_ALLOCATED    = 4'd7;
	localparam logic [STATUS_W-1:0] ST_NONE_FREE    = 4'd8;
	localparam logic [STATUS_W-1:0] ST_RETURNED     = 4'd9;
	localparam logic [STATUS_W-1:0] ST_IN_USE       = 4'd10;
	localparam logic [STATUS_W-1:0] ST_INVALID      = 4'd11;
	localparam logic [STATUS_W-1:0] ST_CLEANED      = 4'd12;
	localparam logic [STATUS_W-1:0] ST_TYPE_SET     = 4'd13;

	typedef struct packed {
		logic [1:0]        owner;
		logic              held;
		logic [TAG_W-1:0]  thread;
		logic [TYPE_W-1:0] etype;
	} rlt_entry_t;

endpackage

// ===== hw/rtl/rlt_table.sv =====
module rlt_table #(
	parameter int NUM_LOCKS   = rlt_pkg::NUM_LOCKS_DEF,
	parameter int COUNT_WIDTH = rlt_pkg::COUNT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [$clog2(NUM_LOCKS)-1:0] wr_idx,
	input  rlt_pkg::rlt_entry_t          wr_entry,
	input  logic [COUNT_WIDTH-1:0]       wr_count,
	input  logic [$clog2(NUM_LOCKS)-1:0] rd_idx,
	output rlt_pkg::rlt_entry_t          rd_entry,
	output logic [COUNT_WIDTH-1:0]       rd_count
);

	rlt_pkg::rlt_entry_t    entry_q [NUM_LOCKS];
	logic [COUNT_WIDTH-1:0] count_q [NUM_LOCKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LOCKS; i++) begin
				entry_q[i].owner  <= rlt_pkg::OWNER_FREE;
				entry_q[i].held   <= 1'b0;
				entry_q[i].thread <= '0;
				entry_q[i].etype  <= rlt_pkg::TYPE_RESET;
				count_q[i]        <= '0;
			end
		end else if (wr_en) begin
			entry_q[wr_idx] <= wr_entry;
			count_q[wr_idx] <= wr_count;
		end
	end

	assign rd_entry = entry_q[rd_idx];
	assign rd_count = count_q[rd_idx];

endmodule

// ===== hw/rtl/recursive_lock_table.sv =====
// Recursive lock table shared by two CPUs. One transaction at a time: after a request
// is taken, in_ready stays low until its result is loaded into the output register.
// Trylock, lock, unlock, return and set type are evaluated once in the execute state, and
// the result is registered from there as soon as the output register is free.
// Allocate walks the pool range one entry per cycle through the single entry update
// unit and stops at the first free slot or at the end of the pool range.
// Cleanup visits every entry once. A new request is
// taken while the previous result still waits on the output; the next result stalls
// there until out_ready frees the register. The table comes out of reset fully
// initialized with no clearing pass.
module recursive_lock_table #(
	parameter int NUM_LOCKS   = rlt_pkg::NUM_LOCKS_DEF,
	parameter int COUNT_WIDTH = rlt_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [rlt_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    req_type,
	input  logic [rlt_pkg::IDX_W-1:0]     lock_index,
	input  logic                          requester_cpu,
	input  logic [rlt_pkg::TAG_W-1:0]     thread_tag,
	input  logic [rlt_pkg::TYPE_W-1:0]    type_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rlt_pkg::STATUS_W-1:0]  status,
	output logic [rlt_pkg::IDX_W-1:0]     slot_index,
	output logic [rlt_pkg::DEPTH_W-1:0]   nest_depth,
	output logic [rlt_pkg::MASK_W-1:0]    released_mask
);

	localparam int IDXW = $clog2(NUM_LOCKS);
	localparam logic [rlt_pkg::PTR_W-1:0] PTR_END = rlt_pkg::PTR_W'(NUM_LOCKS);
	localparam logic [rlt_pkg::PTR_W-1:0] PTR_MASK_END = rlt_pkg::PTR_W'(rlt_pkg::MASK_W);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	localparam logic STATE_IDLE = 1'b0;
	localparam logic STATE_EXEC = 1'b1;

	logic                          state_q;
	logic [rlt_pkg::CFG_W-1:0]     pool_first_q;
	logic [rlt_pkg::CFG_W-1:0]     pool_last_q;
	logic [2:0]                    req_q;
	logic [rlt_pkg::IDX_W-1:0]     idx_q;
	logic                          cpu_q;
	logic [rlt_pkg::TAG_W-1:0]     tag_q;
	logic [rlt_pkg::TYPE_W-1:0]    tval_q;
	logic [rlt_pkg::PTR_W-1:0]     ptr_q;
	logic [rlt_pkg::MASK_W-1:0]    mask_q;

	logic                          out_valid_q;
	logic [rlt_pkg::STATUS_W-1:0]  status_q;
	logic [rlt_pkg::IDX_W-1:0]     slot_q;
	logic [rlt_pkg::DEPTH_W-1:0]   depth_q;
	logic [rlt_pkg::MASK_W-1:0]    rmask_q;

	rlt_pkg::rlt_entry_t           rd_entry;
	logic [COUNT_WIDTH-1:0]        rd_count;
	rlt_pkg::rlt_entry_t           wr_entry;
	logic [COUNT_WIDTH-1:0]        wr_count;
	logic                          wr_req;
	logic                          wr_en;

	logic                          fin;
	logic                          mask_set;
	logic [rlt_pkg::STATUS_W-1:0]  res_status;
	logic [rlt_pkg::IDX_W-1:0]     res_slot;
	logic [COUNT_WIDTH-1:0]        res_depth;
	logic [COUNT_WIDTH+rlt_pkg::DEPTH_W-1:0] depth_ext;

	logic                          in_tab;
	logic                          same_holder;
	logic                          out_free;
	logic                          step_go;
	logic                          accept;

	assign in_ready = (state_q == STATE_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign in_tab   = (ptr_q < PTR_END);
	assign same_holder = (rd_entry.owner == {1'b0, cpu_q}) && (rd_entry.thread == tag_q);
	assign step_go  = (state_q == STATE_EXEC) && (!fin || out_free);
	assign wr_en    = wr_req && step_go;

	rlt_table #(
		.NUM_LOCKS  (NUM_LOCKS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_idx  (ptr_q[IDXW-1:0]),
		.wr_entry(wr_entry),
		.wr_count(wr_count),
		.rd_idx  (ptr_q[IDXW-1:0]),
		.rd_entry(rd_entry),
		.rd_count(rd_count)
	);

	// Shared entry update unit: evaluates the entry under ptr_q for the current request.
	always_comb begin
		wr_req     = 1'b0;
		wr_entry   = rd_entry;
		wr_count   = rd_count;
		fin        = 1'b1;
		mask_set   = 1'b0;
		res_status = rlt_pkg::ST_IGNORED;
		res_slot   = idx_q;
		res_depth  = '0;
		unique case (req_q)
			rlt_pkg::REQ_TRYLOCK, rlt_pkg::REQ_LOCK: begin
				if (!in_tab) begin
					res_status = rlt_pkg::ST_INVALID;
				end else if (!rd_entry.held) begin
					wr_req          = 1'b1;
					wr_entry.owner  = {1'b0, cpu_q};
					wr_entry.held   = 1'b1;
					wr_entry.thread = tag_q;
					wr_count        = COUNT_WIDTH'(1);
					res_status      = rlt_pkg::ST_NEW;
					res_depth       = COUNT_WIDTH'(1);
				end else if (same_holder && (rd_count != COUNT_MAX)) begin
					wr_req     = 1'b1;
					wr_count   = rd_count + COUNT_WIDTH'(1);
					res_status = rlt_pkg::ST_NESTED;
					res_depth  = rd_count + COUNT_WIDTH'(1);
				end else begin
					res_status = (req_q == rlt_pkg::REQ_TRYLOCK) ?
						rlt_pkg::ST_TRY_FAILED : rlt_pkg::ST_RETRY;
					res_depth  = rd_count;
				end
			end
			rlt_pkg::REQ_UNLOCK: begin
				if (!in_tab) begin
					res_status = rlt_pkg::ST_INVALID;
				end else if ((rd_count == '0) || (rd_entry.owner == rlt_pkg::OWNER_FREE) ||
						!rd_entry.held) begin
					res_status = rlt_pkg::ST_IGNORED;
					res_depth  = rd_count;
				end else if (rd_count == COUNT_WIDTH'(1)) begin
					wr_req          = 1'b1;
					wr_entry.owner  = rlt_pkg::OWNER_FREE;
					wr_entry.held   = 1'b0;
					wr_entry.thread = '0;
					wr_count        = '0;
					res_status      = rlt_pkg::ST_FREED;
				end else begin
					wr_req     = 1'b1;
					wr_count   = rd_count - COUNT_WIDTH'(1);
					res_status = rlt_pkg::ST_UNLOCKED_ONE;
					res_depth  = rd_count - COUNT_WIDTH'(1);
				end
			end
			rlt_pkg::REQ_ALLOCATE: begin
				if (!in_tab || (ptr_q > {1'b0, pool_last_q})) begin
					res_status = rlt_pkg::ST_NONE_FREE;
				end else if ((rd_entry.owner == rlt_pkg::OWNER_FREE) && (rd_count == '0) &&
						(rd_entry.etype == rlt_pkg::TYPE_RESET) && !rd_entry.held) begin
					wr_req         = 1'b1;
					wr_entry.owner = {1'b0, cpu_q};
					res_status     = rlt_pkg::ST_ALLOCATED;
					res_slot       = ptr_q[rlt_pkg::IDX_W-1:0];
					res_depth      = rd_count;
				end else begin
					fin = 1'b0;
				end
			end
			rlt_pkg::REQ_RETURN: begin
				if (!in_tab || (idx_q < pool_first_q) || (idx_q > pool_last_q)) begin
					res_status = rlt_pkg::ST_INVALID;
				end else if ((rd_count != '0) || rd_entry.held) begin
					res_status = rlt_pkg::ST_IN_USE;
					res_depth  = rd_count;
				end else begin
					wr_req         = 1'b1;
					wr_entry.owner = rlt_pkg::OWNER_FREE;
					res_status     = rlt_pkg::ST_RETURNED;
				end
			end
			rlt_pkg::REQ_CLEANUP: begin
				res_status = rlt_pkg::ST_CLEANED;
				if (in_tab) begin
					fin = 1'b0;
					if (rd_entry.owner == {1'b0, cpu_q}) begin
						wr_req          = 1'b1;
						wr_entry.owner  = rlt_pkg::OWNER_FREE;
						wr_entry.held   = 1'b0;
						wr_entry.thread = '0;
						wr_count        = '0;
						mask_set        = (ptr_q < PTR_MASK_END);
					end
				end
			end
			rlt_pkg::REQ_SET_TYPE: begin
				if (!in_tab) begin
					res_status = rlt_pkg::ST_INVALID;
				end else begin
					wr_req         = 1'b1;
					wr_entry.etype = tval_q;
					res_status     = rlt_pkg::ST_TYPE_SET;
					res_depth      = rd_count;
				end
			end
			rlt_pkg::REQ_UNUSED: begin
				res_status = rlt_pkg::ST_IGNORED;
			end
			default: begin
				res_status = rlt_pkg::ST_IGNORED;
			end
		endcase
	end

	assign depth_ext = {{rlt_pkg::DEPTH_W{1'b0}}, res_depth};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_first_q <= rlt_pkg::POOL_FIRST_RST;
			pool_last_q  <= rlt_pkg::POOL_LAST_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rlt_pkg::REG_POOL_FIRST: pool_first_q <= cfg_data;
				rlt_pkg::REG_POOL_LAST:  pool_last_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= STATE_EXEC;
			end else if (step_go && fin) begin
				state_q <= STATE_IDLE;
			end
			if (step_go && fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q    <= rlt_pkg::REQ_UNUSED;
			idx_q    <= '0;
			cpu_q    <= 1'b0;
			tag_q    <= '0;
			tval_q   <= '0;
			mask_q   <= '0;
			ptr_q    <= '0;
			status_q <= rlt_pkg::ST_IGNORED;
			slot_q   <= '0;
			depth_q  <= '0;
			rmask_q  <= '0;
		end else if (accept) begin
			req_q  <= req_type;
			idx_q  <= lock_index;
			cpu_q  <= requester_cpu;
			tag_q  <= thread_tag;
			tval_q <= type_value;
			mask_q <= '0;
			priority case (req_type)
				rlt_pkg::REQ_ALLOCATE: ptr_q <= {1'b0, pool_first_q};
				rlt_pkg::REQ_CLEANUP:  ptr_q <= '0;
				default:               ptr_q <= {1'b0, lock_index};
			endcase
		end else if (step_go) begin
			if (fin) begin
				status_q <= res_status;
				slot_q   <= res_slot;
				depth_q  <= depth_ext[rlt_pkg::DEPTH_W-1:0];
				rmask_q  <= (req_q == rlt_pkg::REQ_CLEANUP) ? mask_q : '0;
			end else begin
				// advance the scan and record released entries
				ptr_q <= ptr_q + rlt_pkg::PTR_W'(1);
				if (mask_set) begin
					mask_q[ptr_q[rlt_pkg::IDX_W-1:0]] <= 1'b1;
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slot_index    = slot_q;
	assign nest_depth    = depth_q;
	assign released_mask = rmask_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request taken while previous one still in progress");

	a_mask_only_cleanup: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != rlt_pkg::ST_CLEANED)) |-> (released_mask == '0))
		else $error("released mask set on a non-cleanup result");

	a_cleanup_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == rlt_pkg::ST_CLEANED)) |-> (nest_depth == '0))
		else $error("cleanup result carries a nesting depth");

	a_alloc_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == rlt_pkg::ST_ALLOCATED)) |->
			((slot_index >= pool_first_q) && (slot_index <= pool_last_q)))
		else $error("allocated slot outside pool range");

	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> !($past(step_go) && $past(fin)))
		else $error("result overwrote an untaken transaction");

endmodule

// ===== tb/tb_recursive_lock_table.sv =====
`timescale 1ns / 100ps

module tb_recursive_lock_table;

	localparam int NUM_ENTRIES = rlt_pkg::NUM_LOCKS_DEF;
	localparam logic [rlt_pkg::DEPTH_W-1:0] DEPTH_TOP = '1;
	localparam int PHASES = 7;
	localparam int ITEMS_PER_PHASE = 116;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [rlt_pkg::STATUS_W-1:0] status;
		logic [rlt_pkg::IDX_W-1:0]    slot;
		logic [rlt_pkg::DEPTH_W-1:0]  depth;
		logic [rlt_pkg::MASK_W-1:0]   mask;
	} reply_t;

	typedef struct packed {
		logic [2:0]                 req;
		logic [rlt_pkg::IDX_W-1:0]  idx;
		logic                       cpu;
		logic [rlt_pkg::TAG_W-1:0]  tag;
		logic [rlt_pkg::TYPE_W-1:0] tval;
		logic [16:0]                reps;
		logic                       fixed;
		reply_t                     want;
	} script_row_t;

	localparam int SCRIPT_LEN = 29;
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{rlt_pkg::REQ_TRYLOCK,  4'd0,  1'b0, 32'h0000_0000, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_NEW,          4'd0,  16'd1,     12'h000}},
		'{rlt_pkg::REQ_TRYLOCK,  4'd0,  1'b0, 32'h0000_0000, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_NESTED,       4'd0,  16'd2,     12'h000}},
		'{rlt_pkg::REQ_TRYLOCK,  4'd0,  1'b1, 32'h0000_0000, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_TRY_FAILED,   4'd0,  16'd2,     12'h000}},
		'{rlt_pkg::REQ_LOCK,     4'd0,  1'b0, 32'hFFFF_FFFF, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_RETRY,        4'd0,  16'd2,     12'h000}},
		// unlock ignores who asks
		'{rlt_pkg::REQ_UNLOCK,   4'd0,  1'b1, 32'hFFFF_FFFF, 8'hFF, 17'd1, 1'b1,
			'{rlt_pkg::ST_UNLOCKED_ONE, 4'd0,  16'd1,     12'h000}},
		'{rlt_pkg::REQ_UNLOCK,   4'd0,  1'b0, 32'h0000_0000, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_FREED,        4'd0,  16'd0,     12'h000}},
		'{rlt_pkg::REQ_UNLOCK,   4'd0,  1'b0, 32'h0000_0000, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_IGNORED,      4'd0,  16'd0,     12'h000}},
		'{rlt_pkg::REQ_LOCK,     4'd15, 1'b1, 32'hFFFF_FFFF, 8'hFF, 17'd1, 1'b1,
			'{rlt_pkg::ST_INVALID,      4'd15, 16'd0,     12'h000}},
		'{rlt_pkg::REQ_TRYLOCK,  4'd12, 1'b0, 32'h0000_0001, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_INVALID,      4'd12, 16'd0,     12'h000}},
		'{rlt_pkg::REQ_UNLOCK,   4'd13, 1'b0, 32'h0000_0000, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_INVALID,      4'd13, 16'd0,     12'h000}},
		'{rlt_pkg::REQ_RETURN,   4'd14, 1'b0, 32'h0000_0000, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_INVALID,      4'd14, 16'd0,     12'h000}},
		'{rlt_pkg::REQ_SET_TYPE, 4'd15, 1'b0, 32'h0000_0000, 8'hFF, 17'd1, 1'b1,
			'{rlt_pkg::ST_INVALID,      4'd15, 16'd0,     12'h000}},
		'{rlt_pkg::REQ_ALLOCATE, 4'd0,  1'b1, 32'h0000_0000, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_ALLOCATED,    4'd5,  16'd0,     12'h000}},
		// allocated slot has no holder: the lock takes it as new
		'{rlt_pkg::REQ_LOCK,     4'd5,  1'b0, 32'hA5A5_A5A5, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_NEW,          4'd5,  16'd1,     12'h000}},
		'{rlt_pkg::REQ_RETURN,   4'd5,  1'b0, 32'h0000_0000, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_IN_USE,       4'd5,  16'd1,     12'h000}},
		'{rlt_pkg::REQ_RETURN,   4'd4,  1'b0, 32'h0000_0000, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_INVALID,      4'd4,  16'd0,     12'h000}},
		'{rlt_pkg::REQ_SET_TYPE, 4'd6,  1'b0, 32'h0000_0000, 8'hFF, 17'd1, 1'b1,
			'{rlt_pkg::ST_TYPE_SET,     4'd6,  16'd0,     12'h000}},
		'{rlt_pkg::REQ_ALLOCATE, 4'd0,  1'b0, 32'h0000_0000, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_ALLOCATED,    4'd7,  16'd0,     12'h000}},
		'{rlt_pkg::REQ_UNLOCK,   4'd7,  1'b0, 32'h0000_0000, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_IGNORED,      4'd7,  16'd0,     12'h000}},
		'{rlt_pkg::REQ_CLEANUP,  4'd0,  1'b0, 32'h0000_0000, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_CLEANED,      4'd0,  16'd0,     12'h0A0}},
		'{rlt_pkg::REQ_RETURN,   4'd6,  1'b0, 32'h0000_0000, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_RETURNED,     4'd6,  16'd0,     12'h000}},
		'{rlt_pkg::REQ_UNUSED,   4'd3,  1'b1, 32'hFFFF_FFFF, 8'hFF, 17'd1, 1'b1,
			'{rlt_pkg::ST_IGNORED,      4'd3,  16'd0,     12'h000}},
		'{rlt_pkg::REQ_SET_TYPE, 4'd6,  1'b0, 32'h0000_0000, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_TYPE_SET,     4'd6,  16'd0,     12'h000}},
		'{rlt_pkg::REQ_SET_TYPE, 4'd6,  1'b1, 32'h0000_0000, 8'h02, 17'd1, 1'b1,
			'{rlt_pkg::ST_TYPE_SET,     4'd6,  16'd0,     12'h000}},
		// nest a few levels deep
		'{rlt_pkg::REQ_LOCK,     4'd11, 1'b1, 32'h1234_5678, 8'h00, 17'd3, 1'b0, '0},
		'{rlt_pkg::REQ_LOCK,     4'd11, 1'b1, 32'h1234_5678, 8'h00, 17'd1, 1'b0, '0},
		'{rlt_pkg::REQ_TRYLOCK,  4'd11, 1'b0, 32'h1234_5678, 8'h00, 17'd1, 1'b0, '0},
		'{rlt_pkg::REQ_CLEANUP,  4'd0,  1'b1, 32'h0000_0000, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_CLEANED,      4'd0,  16'd0,     12'h800}},
		'{rlt_pkg::REQ_CLEANUP,  4'd15, 1'b1, 32'h0000_0000, 8'h00, 17'd1, 1'b1,
			'{rlt_pkg::ST_CLEANED,      4'd15, 16'd0,     12'h000}}
	};

	localparam logic [rlt_pkg::CFG_W-1:0] FIRST_SET [PHASES] =
		'{4'd5, 4'd0, 4'd11, 4'd0, 4'd9, 4'd13, 4'd2};
	localparam logic [rlt_pkg::CFG_W-1:0] LAST_SET [PHASES] =
		'{4'd11, 4'd11, 4'd11, 4'd0, 4'd3, 4'd15, 4'd14};

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic                         cfg_index;
	logic [rlt_pkg::CFG_W-1:0]    cfg_data;
	logic                         in_valid;
	logic                         in_ready;
	logic [2:0]                   req_type;
	logic [rlt_pkg::IDX_W-1:0]    lock_index;
	logic                         requester_cpu;
	logic [rlt_pkg::TAG_W-1:0]    thread_tag;
	logic [rlt_pkg::TYPE_W-1:0]   type_value;
	logic                         out_valid;
	logic                         out_ready;
	logic [rlt_pkg::STATUS_W-1:0] status;
	logic [rlt_pkg::IDX_W-1:0]    slot_index;
	logic [rlt_pkg::DEPTH_W-1:0]  nest_depth;
	logic [rlt_pkg::MASK_W-1:0]   released_mask;

	// shadow of the lock table
	logic [1:0]                  tbl_owner  [NUM_ENTRIES];
	logic                        tbl_held   [NUM_ENTRIES];
	logic [rlt_pkg::TAG_W-1:0]   tbl_thread [NUM_ENTRIES];
	logic [rlt_pkg::DEPTH_W-1:0] tbl_count  [NUM_ENTRIES];
	logic [rlt_pkg::TYPE_W-1:0]  tbl_type   [NUM_ENTRIES];
	logic [rlt_pkg::CFG_W-1:0]   pool_first;
	logic [rlt_pkg::CFG_W-1:0]   pool_last;

	reply_t                    awaited_replies[$];
	logic [rlt_pkg::TAG_W-1:0] thread_pool [4];
	bit                        no_idle;
	int                        hold_pending;
	int                        mismatches;
	int                        quiet_cycles;

	recursive_lock_table i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.lock_index    (lock_index),
		.requester_cpu (requester_cpu),
		.thread_tag    (thread_tag),
		.type_value    (type_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.slot_index    (slot_index),
		.nest_depth    (nest_depth),
		.released_mask (released_mask)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void release_entry(input int i);
		tbl_owner[i]  = rlt_pkg::OWNER_FREE;
		tbl_held[i]   = 1'b0;
		tbl_thread[i] = '0;
		tbl_count[i]  = '0;
	endfunction

	function automatic void clear_table();
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			release_entry(i);
			tbl_type[i] = rlt_pkg::TYPE_RESET;
		end
		pool_first = rlt_pkg::POOL_FIRST_RST;
		pool_last  = rlt_pkg::POOL_LAST_RST;
	endfunction

	function automatic reply_t apply_lock_request(input logic [2:0] req,
			input logic [rlt_pkg::IDX_W-1:0] idx, input logic cpu,
			input logic [rlt_pkg::TAG_W-1:0] tag, input logic [rlt_pkg::TYPE_W-1:0] tval);
		reply_t r;
		bit     in_table;
		bit     found;
		int     i;
		r.status = rlt_pkg::ST_IGNORED;
		r.slot   = idx;
		r.depth  = '0;
		r.mask   = '0;
		in_table = int'(idx) < NUM_ENTRIES;
		case (req)
			rlt_pkg::REQ_TRYLOCK, rlt_pkg::REQ_LOCK: begin
				if (!in_table) begin
					r.status = rlt_pkg::ST_INVALID;
				end else if (!tbl_held[idx]) begin
					tbl_owner[idx]  = {1'b0, cpu};
					tbl_held[idx]   = 1'b1;
					tbl_thread[idx] = tag;
					tbl_count[idx]  = rlt_pkg::DEPTH_W'(1);
					r.status = rlt_pkg::ST_NEW;
					r.depth  = rlt_pkg::DEPTH_W'(1);
				end else if (tbl_owner[idx] == {1'b0, cpu} && tbl_thread[idx] == tag &&
						tbl_count[idx] != DEPTH_TOP) begin
					tbl_count[idx] = tbl_count[idx] + 1'b1;
					r.status = rlt_pkg::ST_NESTED;
					r.depth  = tbl_count[idx];
				end else begin
					r.status = (req == rlt_pkg::REQ_TRYLOCK) ?
						rlt_pkg::ST_TRY_FAILED : rlt_pkg::ST_RETRY;
					r.depth  = tbl_count[idx];
				end
			end
			rlt_pkg::REQ_UNLOCK: begin
				if (!in_table) begin
					r.status = rlt_pkg::ST_INVALID;
				end else if (tbl_count[idx] == '0 || tbl_owner[idx] == rlt_pkg::OWNER_FREE ||
						!tbl_held[idx]) begin
					r.depth = tbl_count[idx];
				end else begin
					tbl_count[idx] = tbl_count[idx] - 1'b1;
					if (tbl_count[idx] == '0) begin
						release_entry(int'(idx));
						r.status = rlt_pkg::ST_FREED;
					end else begin
						r.status = rlt_pkg::ST_UNLOCKED_ONE;
					end
					r.depth = tbl_count[idx];
				end
			end
			rlt_pkg::REQ_ALLOCATE: begin
				r.status = rlt_pkg::ST_NONE_FREE;
				found = 1'b0;
				for (i = int'(pool_first); i <= int'(pool_last) && i < NUM_ENTRIES; i++) begin
					if (!found && tbl_owner[i] == rlt_pkg::OWNER_FREE && tbl_count[i] == '0 &&
							tbl_type[i] == rlt_pkg::TYPE_RESET && !tbl_held[i]) begin
						found = 1'b1;
						tbl_owner[i] = {1'b0, cpu};
						r.status = rlt_pkg::ST_ALLOCATED;
						r.slot   = rlt_pkg::IDX_W'(i);
						r.depth  = tbl_count[i];
					end
				end
			end
			rlt_pkg::REQ_RETURN: begin
				if (!in_table || idx < pool_first || idx > pool_last) begin
					r.status = rlt_pkg::ST_INVALID;
				end else if (tbl_count[idx] != '0 || tbl_held[idx]) begin
					r.status = rlt_pkg::ST_IN_USE;
					r.depth  = tbl_count[idx];
				end else begin
					tbl_owner[idx] = rlt_pkg::OWNER_FREE;
					r.status = rlt_pkg::ST_RETURNED;
				end
			end
			rlt_pkg::REQ_CLEANUP: begin
				for (i = 0; i < NUM_ENTRIES; i++) begin
					if (tbl_owner[i] == {1'b0, cpu}) begin
						release_entry(i);
						if (i < rlt_pkg::MASK_W)
							r.mask[i] = 1'b1;
					end
				end
				r.status = rlt_pkg::ST_CLEANED;
			end
			rlt_pkg::REQ_SET_TYPE: begin
				if (!in_table) begin
					r.status = rlt_pkg::ST_INVALID;
				end else begin
					tbl_type[idx] = tval;
					r.status = rlt_pkg::ST_TYPE_SET;
					r.depth  = tbl_count[idx];
				end
			end
			default: r.status = rlt_pkg::ST_IGNORED;
		endcase
		return r;
	endfunction

	// offer one transaction, then queue its reply
	task automatic issue(input logic [2:0] req, input logic [rlt_pkg::IDX_W-1:0] idx,
			input logic cpu, input logic [rlt_pkg::TAG_W-1:0] tag,
			input logic [rlt_pkg::TYPE_W-1:0] tval, input logic fixed, input reply_t want);
		int     gap;
		reply_t predicted;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		req_type      <= req;
		lock_index    <= idx;
		requester_cpu <= cpu;
		thread_tag    <= tag;
		type_value    <= tval;
		do @(posedge clk); while (!in_ready);
		predicted = apply_lock_request(req, idx, cpu, tag, tval);
		awaited_replies.push_back(fixed ? want : predicted);
	endtask

	task automatic issue_random(output bit counted);
		logic [2:0]                 req;
		logic [rlt_pkg::IDX_W-1:0]  idx;
		logic [rlt_pkg::TAG_W-1:0]  tag;
		logic [rlt_pkg::TYPE_W-1:0] tval;
		int                         pick;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			req = rlt_pkg::REQ_LOCK;
		else if (pick < 38)
			req = rlt_pkg::REQ_TRYLOCK;
		else if (pick < 62)
			req = rlt_pkg::REQ_UNLOCK;
		else if (pick < 74)
			req = rlt_pkg::REQ_ALLOCATE;
		else if (pick < 86)
			req = rlt_pkg::REQ_RETURN;
		else if (pick < 91)
			req = rlt_pkg::REQ_CLEANUP;
		else if (pick < 98)
			req = rlt_pkg::REQ_SET_TYPE;
		else
			req = rlt_pkg::REQ_UNUSED;
		idx  = ($urandom_range(0, 9) == 0) ? rlt_pkg::IDX_W'($urandom_range(12, 15))
			: rlt_pkg::IDX_W'($urandom_range(0, NUM_ENTRIES - 1));
		tag  = ($urandom_range(0, 9) == 0) ? $urandom : thread_pool[$urandom_range(0, 3)];
		tval = ($urandom_range(0, 2) == 0) ? rlt_pkg::TYPE_W'($urandom_range(0, 255))
			: rlt_pkg::TYPE_RESET;
		issue(req, idx, 1'($urandom_range(0, 1)), tag, tval, 1'b0, '0);
		counted = (req != rlt_pkg::REQ_UNUSED);
	endtask

	task automatic write_pool(input logic [rlt_pkg::CFG_W-1:0] first,
			input logic [rlt_pkg::CFG_W-1:0] last);
		cfg_we    <= 1'b1;
		cfg_index <= rlt_pkg::REG_POOL_FIRST;
		cfg_data  <= first;
		@(posedge clk);
		cfg_index <= rlt_pkg::REG_POOL_LAST;
		cfg_data  <= last;
		@(posedge clk);
		cfg_we <= 1'b0;
		pool_first = first;
		pool_last  = last;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	// reply side
	initial begin
		int     stall;
		reply_t got;
		reply_t want;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = (hold_pending > 0) ? hold_pending : (no_idle ? 0 : $urandom_range(0, 4));
			hold_pending = 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got = '{status, slot_index, nest_depth, released_mask};
			if (awaited_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: reply with none outstanding: status %0d slot %0d %s%0d mask %h",
						$realtime, got.status, got.slot, "depth ", got.depth, got.mask);
			end else begin
				want = awaited_replies.pop_front();
				if (got.status !== want.status || got.slot !== want.slot ||
						got.depth !== want.depth || got.mask !== want.mask) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"%0t: mismatch exp status %0d slot %0d depth %0d mask %h,",
							" got status %0d slot %0d depth %0d mask %h"},
							$realtime, want.status, want.slot, want.depth, want.mask,
							got.status, got.slot, got.depth, got.mask);
				end
			end
		end
	end

	// abort when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("recursive_lock_table verification failed");
				$finish;
			end
		end
	end

	initial begin
		int done;
		bit counted;
		mismatches    = 0;
		hold_pending  = 0;
		no_idle       = 1'b0;
		quiet_cycles  = 0;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= rlt_pkg::REG_POOL_FIRST;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		req_type      <= rlt_pkg::REQ_TRYLOCK;
		lock_index    <= '0;
		requester_cpu <= 1'b0;
		thread_tag    <= '0;
		type_value    <= '0;
		clear_table();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (SCRIPT[r]) begin
			// keep the nesting run tight
			no_idle = (SCRIPT[r].reps > 1);
			for (int n = 0; n < int'(SCRIPT[r].reps); n++)
				issue(SCRIPT[r].req, SCRIPT[r].idx, SCRIPT[r].cpu, SCRIPT[r].tag,
					SCRIPT[r].tval, SCRIPT[r].fixed, SCRIPT[r].want);
		end
		no_idle = 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			write_pool(FIRST_SET[ph], LAST_SET[ph]);
			thread_pool[0] = '0;
			thread_pool[1] = '1;
			thread_pool[2] = $urandom;
			thread_pool[3] = $urandom;
			no_idle = (ph == 3);
			if (ph == 2)
				hold_pending = HOLD_CYCLES;
			done = 0;
			while (done < ITEMS_PER_PHASE) begin
				issue_random(counted);
				done += int'(counted);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_replies.size() == 0)
			$display("recursive_lock_table verification clean");
		else
			$display("recursive_lock_table verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/rlt_pkg.sv
hw/rtl/rlt_table.sv
hw/rtl/recursive_lock_table.sv
tb/tb_recursive_lock_table.sv
